// ===== rtl/svc_pkg.sv =====
// ----------------------------------------------------------------------------
// svc_pkg - shared types and codes for the solenoid valve command controller
// State codes, register indexes, configuration and drive-state structs.
// ----------------------------------------------------------------------------
package svc_pkg;

  localparam int TIMER_BITS_DEF = 32;

  localparam int STATE_W = 4;
  localparam int DUTY_W  = 12;
  localparam int REG_IDX_W = 3;

  // valve state codes
  localparam logic [STATE_W-1:0] ST_CLOSED         = 4'd0;
  localparam logic [STATE_W-1:0] ST_OPEN           = 4'd1;
  localparam logic [STATE_W-1:0] ST_OPEN_CMD       = 4'd2;
  localparam logic [STATE_W-1:0] ST_CLOSE_CMD      = 4'd3;
  localparam logic [STATE_W-1:0] ST_OPEN_PROC      = 4'd4;
  localparam logic [STATE_W-1:0] ST_CLOSE_PROC     = 4'd5;
  localparam logic [STATE_W-1:0] ST_FIRE           = 4'd6;
  localparam logic [STATE_W-1:0] ST_BANG_OPEN_CMD  = 4'd7;
  localparam logic [STATE_W-1:0] ST_BANG_CLOSE_CMD = 4'd8;
  localparam logic [STATE_W-1:0] ST_BANG_OPEN_PROC = 4'd9;
  localparam logic [STATE_W-1:0] ST_BANGING_OPEN   = 4'd10;
  localparam logic [STATE_W-1:0] ST_BANGING_CLOSED = 4'd11;

  // register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_VALVE_TYPE     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FULL_DUTY_TIME = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FULL_DUTY      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HOLD_DUTY      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FIRE_TIME      = 3'd4;

  // func field codes
  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_COMMAND = 1'b1;

  localparam logic [DUTY_W-1:0] DUTY_FULL_SCALE = 12'hFFF;
  localparam logic [DUTY_W-1:0] FULL_DUTY_RST   = 12'd4095;

  typedef struct packed {
    logic               valve_type;
    logic [31:0]        full_duty_time;
    logic [DUTY_W-1:0]  full_duty;
    logic [DUTY_W-1:0]  hold_duty;
    logic signed [31:0] fire_time;
  } cfg_t;

  typedef struct packed {
    logic [STATE_W-1:0] cur;
    logic [STATE_W-1:0] prev;
    logic [DUTY_W-1:0]  duty;
    logic               drive;
  } vstate_t;

endpackage

// ===== rtl/svc_in_if.sv =====
// ----------------------------------------------------------------------------
// svc_in_if - input item channel
// valid/ready handshake with tick/command payload.
// ----------------------------------------------------------------------------
interface svc_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [3:0]         command_state;
  logic signed [31:0] sequence_time;

  modport source (output valid, output func, output command_state,
                  output sequence_time, input ready);
  modport sink   (input valid, input func, input command_state,
                  input sequence_time, output ready);
endinterface

// ===== rtl/svc_out_if.sv =====
// ----------------------------------------------------------------------------
// svc_out_if - result channel
// valid/ready handshake with valve state and coil drive payload.
// ----------------------------------------------------------------------------
interface svc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  valve_state;
  logic [3:0]  prior_state;
  logic [11:0] pwm_duty;
  logic        drive_on;
  logic        state_changed;

  modport source (output valid, output valve_state, output prior_state,
                  output pwm_duty, output drive_on, output state_changed,
                  input ready);
  modport sink   (input valid, input valve_state, input prior_state,
                  input pwm_duty, input drive_on, input state_changed,
                  output ready);
endinterface

// ===== rtl/solenoid_valve_command_fsm_core.sv =====
// Each input transaction is held in the input register, then the result register.
// Throughput: one transaction per cycle unless out_ch stalls; the state update
//   is one svc_step pass between the input register and the result/state registers.
// Reset (rst_n low, synchronous): valve at rest (closed), counter, duty and
//   drive cleared, registers at their defaults, both pipeline stages empty.
// ----------------------------------------------------------------------------
// solenoid_valve_command_fsm_core - peak-and-hold solenoid valve controller
// Tick and command transactions drive the valve state machine; each one
// returns the valve state, prior state and coil drive.
// ----------------------------------------------------------------------------
module solenoid_valve_command_fsm_core #(
  parameter int TIMER_BITS = svc_pkg::TIMER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  svc_in_if.sink      in_ch,
  svc_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  svc_pkg::cfg_t    cfg;
  logic             type_wr;

  // input stage
  logic               s1_valid_r;
  logic               s1_func_r;
  logic [3:0]         s1_cmd_r;
  logic signed [31:0] s1_seq_r;

  // controller state
  svc_pkg::vstate_t      st_r, st_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic                  moved;

  // result stage
  logic             out_valid_r;
  svc_pkg::vstate_t res_r;
  logic             res_moved_r;

  logic adv;      // input stage hands its transaction to the result stage
  logic s1_load;

  svc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg),
    .type_wr (type_wr)
  );

  svc_step #(.TIMER_BITS(TIMER_BITS)) u_step (
    .func          (s1_func_r),
    .command_state (s1_cmd_r),
    .sequence_time (s1_seq_r),
    .cfg           (cfg),
    .st            (st_r),
    .elapsed       (elapsed_r),
    .st_nxt        (st_nxt),
    .elapsed_nxt   (elapsed_nxt),
    .moved         (moved)
  );

  // result register frees whenever it is empty or being taken
  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign s1_load      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_func_r <= in_ch.func;
      s1_cmd_r  <= in_ch.command_state;
      s1_seq_r  <= in_ch.sequence_time;
    end
  end

  // State advances together with the result register. The user must write valve_type
  // only while idle (not enforced); it puts both states at the new rest position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.cur   <= svc_pkg::ST_CLOSED;
      st_r.prev  <= svc_pkg::ST_CLOSED;
      st_r.duty  <= '0;
      st_r.drive <= 1'b0;
      elapsed_r  <= '0;
    end else if (type_wr) begin
      st_r.cur  <= cfg_pwdata[0] ? svc_pkg::ST_OPEN : svc_pkg::ST_CLOSED;
      st_r.prev <= cfg_pwdata[0] ? svc_pkg::ST_OPEN : svc_pkg::ST_CLOSED;
    end else if (adv) begin
      st_r      <= st_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r       <= st_nxt;
      res_moved_r <= moved;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.valve_state   = res_r.cur;
  assign out_ch.prior_state   = res_r.prev;
  assign out_ch.pwm_duty      = res_r.duty;
  assign out_ch.drive_on      = res_r.drive;
  assign out_ch.state_changed = res_moved_r;

  // pull-in states always show full duty with the driver on
  a_pullin_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.cur == svc_pkg::ST_OPEN_PROC ||
                     res_r.cur == svc_pkg::ST_BANG_OPEN_PROC ||
                     res_r.cur == svc_pkg::ST_CLOSE_PROC))
    |-> (res_r.duty == cfg.full_duty && res_r.drive))
    else $error("pull-in state without full duty drive");

  // banging open drives full scale
  a_bang_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.cur == svc_pkg::ST_BANGING_OPEN)
    |-> (res_r.duty == svc_pkg::DUTY_FULL_SCALE && res_r.drive))
    else $error("banging open without full-scale drive");

  // a transaction leaving the input stage always lands in the result stage
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_valid_r && res_r.cur == $past(st_nxt.cur)))
    else $error("transaction lost between stages");

endmodule

// ===== rtl/svc_cfg.sv =====
// ----------------------------------------------------------------------------
// svc_cfg - APB-style configuration register file
// Holds the five controller registers; flags a valve_type write.
// ----------------------------------------------------------------------------
module svc_cfg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output svc_pkg::cfg_t        cfg,
  output logic                 type_wr
);

  svc_pkg::cfg_t                 cfg_r;
  logic [svc_pkg::REG_IDX_W-1:0] idx;
  logic                          wr;

  assign pready  = 1'b1;
  assign idx     = paddr[4:2];
  assign wr      = psel & penable & pwrite & pready;
  assign type_wr = wr && (idx == svc_pkg::REG_VALVE_TYPE);
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.valve_type     <= 1'b0;
      cfg_r.full_duty_time <= '0;
      cfg_r.full_duty      <= svc_pkg::FULL_DUTY_RST;
      cfg_r.hold_duty      <= '0;
      cfg_r.fire_time      <= '0;
    end else if (wr) begin
      case (idx)
        svc_pkg::REG_VALVE_TYPE:     cfg_r.valve_type     <= pwdata[0];
        svc_pkg::REG_FULL_DUTY_TIME: cfg_r.full_duty_time <= pwdata;
        svc_pkg::REG_FULL_DUTY:      cfg_r.full_duty      <= pwdata[11:0];
        svc_pkg::REG_HOLD_DUTY:      cfg_r.hold_duty      <= pwdata[11:0];
        svc_pkg::REG_FIRE_TIME:      cfg_r.fire_time      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      svc_pkg::REG_VALVE_TYPE:     prdata = {31'd0, cfg_r.valve_type};
      svc_pkg::REG_FULL_DUTY_TIME: prdata = cfg_r.full_duty_time;
      svc_pkg::REG_FULL_DUTY:      prdata = {20'd0, cfg_r.full_duty};
      svc_pkg::REG_HOLD_DUTY:      prdata = {20'd0, cfg_r.hold_duty};
      svc_pkg::REG_FIRE_TIME:      prdata = cfg_r.fire_time;
      default:                     prdata = '0;
    endcase
  end

endmodule

// ===== rtl/svc_step.sv =====
// ----------------------------------------------------------------------------
// svc_step - one controller step
// Next valve state, elapsed counter and coil drive for one item.
// ----------------------------------------------------------------------------
module svc_step #(
  parameter int TIMER_BITS = svc_pkg::TIMER_BITS_DEF
) (
  input  logic                   func,
  input  logic [3:0]             command_state,
  input  logic signed [31:0]     sequence_time,
  input  svc_pkg::cfg_t          cfg,
  input  svc_pkg::vstate_t       st,
  input  logic [TIMER_BITS-1:0]  elapsed,
  output svc_pkg::vstate_t       st_nxt,
  output logic [TIMER_BITS-1:0]  elapsed_nxt,
  output logic                   moved
);

  logic [TIMER_BITS-1:0] el_inc;
  logic                  pullin_done;
  logic [3:0]            cur_n;
  logic [3:0]            prev_n;

  // saturating tick count, compared after the increment
  assign el_inc      = (&elapsed) ? elapsed : elapsed + TIMER_BITS'(1);
  assign pullin_done = 32'(el_inc) >= cfg.full_duty_time;

  always_comb begin
    cur_n       = st.cur;
    prev_n      = st.prev;
    elapsed_nxt = elapsed;
    moved       = 1'b0;
    if (func == svc_pkg::FUNC_COMMAND) begin
      if (command_state <= svc_pkg::ST_BANGING_CLOSED) begin
        prev_n = st.cur;
        cur_n  = command_state;
        moved  = 1'b1;
      end
    end else begin
      elapsed_nxt = el_inc;
      case (st.cur)
        svc_pkg::ST_OPEN_CMD: begin
          if (st.prev != svc_pkg::ST_OPEN && st.prev != svc_pkg::ST_OPEN_PROC) begin
            elapsed_nxt = '0;
            prev_n = st.cur;
            cur_n  = cfg.valve_type ? svc_pkg::ST_OPEN : svc_pkg::ST_OPEN_PROC;
          end else begin
            cur_n = st.prev;
          end
          moved = 1'b1;
        end
        svc_pkg::ST_BANG_OPEN_CMD: begin
          if (st.prev != svc_pkg::ST_OPEN) begin
            elapsed_nxt = '0;
            prev_n = st.cur;
            cur_n  = cfg.valve_type ? svc_pkg::ST_OPEN : svc_pkg::ST_BANG_OPEN_PROC;
          end else begin
            cur_n = svc_pkg::ST_OPEN;
          end
          moved = 1'b1;
        end
        svc_pkg::ST_CLOSE_CMD: begin
          if (st.prev != svc_pkg::ST_CLOSED && st.prev != svc_pkg::ST_CLOSE_PROC) begin
            elapsed_nxt = '0;
            prev_n = st.cur;
            cur_n  = cfg.valve_type ? svc_pkg::ST_CLOSE_PROC : svc_pkg::ST_CLOSED;
          end else begin
            cur_n = st.prev;
          end
          moved = 1'b1;
        end
        svc_pkg::ST_BANG_CLOSE_CMD: begin
          if (st.prev != svc_pkg::ST_CLOSED) begin
            elapsed_nxt = '0;
            prev_n = st.cur;
            cur_n  = cfg.valve_type ? svc_pkg::ST_CLOSE_PROC
                                    : svc_pkg::ST_BANGING_CLOSED;
          end else begin
            cur_n = st.prev;
          end
          moved = 1'b1;
        end
        svc_pkg::ST_OPEN_PROC, svc_pkg::ST_BANG_OPEN_PROC,
        svc_pkg::ST_CLOSE_PROC: begin
          if (pullin_done) begin
            elapsed_nxt = '0;
            prev_n = st.cur;
            case (st.cur)
              svc_pkg::ST_OPEN_PROC:      cur_n = svc_pkg::ST_OPEN;
              svc_pkg::ST_BANG_OPEN_PROC: cur_n = svc_pkg::ST_BANGING_OPEN;
              default:                    cur_n = svc_pkg::ST_CLOSED;
            endcase
            moved = 1'b1;
          end
        end
        svc_pkg::ST_FIRE: begin
          if (sequence_time >= cfg.fire_time) begin
            cur_n = svc_pkg::ST_OPEN_CMD;
            moved = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // coil drive from the new state; command and fire states keep the last drive
  always_comb begin
    st_nxt.cur   = cur_n;
    st_nxt.prev  = prev_n;
    st_nxt.duty  = st.duty;
    st_nxt.drive = st.drive;
    case (cur_n)
      svc_pkg::ST_OPEN_PROC, svc_pkg::ST_BANG_OPEN_PROC,
      svc_pkg::ST_CLOSE_PROC: begin
        st_nxt.duty  = cfg.full_duty;
        st_nxt.drive = 1'b1;
      end
      svc_pkg::ST_CLOSED: begin
        st_nxt.duty  = cfg.valve_type ? cfg.hold_duty : '0;
        st_nxt.drive = cfg.valve_type;
      end
      svc_pkg::ST_OPEN: begin
        st_nxt.duty  = cfg.valve_type ? '0 : cfg.hold_duty;
        st_nxt.drive = ~cfg.valve_type;
      end
      svc_pkg::ST_BANGING_OPEN: begin
        st_nxt.duty  = svc_pkg::DUTY_FULL_SCALE;
        st_nxt.drive = 1'b1;
      end
      svc_pkg::ST_BANGING_CLOSED: begin
        st_nxt.duty  = '0;
        st_nxt.drive = 1'b0;
      end
      default: ;
    endcase
  end

endmodule
